@@ src/ppmf_pkg.sv @@
// Package for the projected point mask filter: payload types, codes and constants.
`default_nettype none
package ppmf_pkg;

  localparam int DEF_MAP_COLS_MAX = 1024;
  localparam int DEF_MAP_ROWS_MAX = 512;
  localparam int DEF_COUNT_BITS   = 24;

  localparam int COEFF_W    = 48;
  localparam int POINT_W    = 32;
  localparam int ACC_W      = 85;
  localparam int PROD_W     = 57;
  localparam int QUOT_BITS  = 13;
  localparam int DIV_W      = 100;
  localparam int NUM_COEFFS = 12;
  localparam int MUL_STEPS  = 18;
  localparam int RES_COUNT_W = 24;

  localparam logic [7:0]  THR_RESET  = 8'd150;
  localparam logic [10:0] COLS_RESET = 11'd640;
  localparam logic [9:0]  ROWS_RESET = 10'd512;

  typedef enum logic [1:0] {
    ACT_COEFF   = 2'd0,
    ACT_MAP     = 2'd1,
    ACT_PROJECT = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_MAP_COLS  = 2'd1,
    REG_MAP_ROWS  = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DINIT,
    ST_DSTEP,
    ST_DLATCH,
    ST_MRD,
    ST_RES
  } state_t;

  typedef struct packed {
    action_t            action;
    logic [3:0]         coeff_index;
    logic signed [47:0] coeff_value;
    logic [18:0]        map_address;
    logic [7:0]         map_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } item_t;

  typedef struct packed {
    logic        in_view;
    logic        inlier;
    logic [9:0]  pixel_u;
    logic [8:0]  pixel_v;
    logic [23:0] inlier_count;
  } result_t;

  typedef struct packed {
    logic [7:0]  threshold;
    logic [10:0] map_cols;
    logic [9:0]  map_rows;
  } cfg_t;

  typedef struct packed {
    logic       accept;
    logic       project_start;
    logic       mul_issue;
    logic       acc_en;
    logic [4:0] mul_step;
    logic       div_init;
    logic       div_step;
    logic       div_latch;
    logic       sel_v;
    logic       map_rd;
    logic       res_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

@@ src/ppmf_regs.sv @@
// Configuration register bank behind the APB-style port.
`default_nettype none
module ppmf_regs
  import ppmf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  reg_index_t idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = reg_index_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= THR_RESET;
      cfg.map_cols  <= COLS_RESET;
      cfg.map_rows  <= ROWS_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_THRESHOLD: cfg.threshold <= pwdata[7:0];
        REG_MAP_COLS:  cfg.map_cols  <= pwdata[10:0];
        REG_MAP_ROWS:  cfg.map_rows  <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (idx)
      REG_THRESHOLD: prdata = {24'd0, cfg.threshold};
      REG_MAP_COLS:  prdata = {21'd0, cfg.map_cols};
      REG_MAP_ROWS:  prdata = {22'd0, cfg.map_rows};
      default:       prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

@@ src/ppmf_ctrl.sv @@
// Controller state machine that sequences the projection datapath.
`default_nettype none
module ppmf_ctrl
  import ppmf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  input  wire action_t item_action,
  output logic         item_ready,
  output cmd_t         cmd,
  input  wire status_t status
);

  localparam int CW = $clog2(MUL_STEPS + 1);
  localparam int DW = $clog2(QUOT_BITS);

  state_t        state, state_next;
  logic [CW-1:0] cnt;
  logic [DW-1:0] dcnt;
  logic          sel_v;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (item_valid && item_action == ACT_PROJECT) state_next = ST_MUL;
      ST_MUL:    if (cnt == CW'(MUL_STEPS)) state_next = ST_DINIT;
      ST_DINIT:  state_next = ST_DSTEP;
      ST_DSTEP:  if (dcnt == DW'(QUOT_BITS - 1)) state_next = ST_DLATCH;
      ST_DLATCH: state_next = sel_v ? ST_MRD : ST_DINIT;
      ST_MRD:    state_next = ST_RES;
      ST_RES:    if (status.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    item_ready        = (state == ST_IDLE);
    cmd               = '0;
    cmd.accept        = item_ready && item_valid;
    cmd.project_start = cmd.accept && item_action == ACT_PROJECT;
    cmd.mul_step      = 5'(cnt);
    cmd.mul_issue     = (state == ST_MUL) && cnt != CW'(MUL_STEPS);
    cmd.acc_en        = (state == ST_MUL) && cnt != '0;
    cmd.div_init      = (state == ST_DINIT);
    cmd.div_step      = (state == ST_DSTEP);
    cmd.div_latch     = (state == ST_DLATCH);
    cmd.sel_v         = sel_v;
    cmd.map_rd        = (state == ST_MRD);
    cmd.res_load      = (state == ST_RES) && status.out_free;
  end

  // State and step counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      dcnt  <= '0;
      sel_v <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= (state == ST_MUL) ? cnt + 1'b1 : '0;
      dcnt  <= (state == ST_DSTEP) ? dcnt + 1'b1 : '0;
      if (state == ST_IDLE) begin
        sel_v <= 1'b0;
      end else if (state == ST_DLATCH) begin
        sel_v <= 1'b1;
      end
    end
  end

  a_mul_to_div: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL && cnt == CW'(MUL_STEPS) |=> state == ST_DINIT)
    else $error("multiply phase did not hand over to the divider");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.project_start |=> !item_ready)
    else $error("new transaction accepted during a projection");
  a_res_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> state == ST_IDLE)
    else $error("result load did not return to idle");

endmodule
`default_nettype wire

@@ src/ppmf_datapath.sv @@
// Datapath: coefficient store, shared multiplier, accumulators, divider, map and result.
`default_nettype none
module ppmf_datapath
  import ppmf_pkg::*;
#(
  parameter int MAP_COLS_MAX = DEF_MAP_COLS_MAX,
  parameter int MAP_ROWS_MAX = DEF_MAP_ROWS_MAX,
  parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  input  wire cmd_t  cmd,
  output status_t    status,
  output logic       result_valid,
  input  wire logic  result_ready,
  output result_t    result
);

  localparam int DEPTH = MAP_COLS_MAX * MAP_ROWS_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic signed [COEFF_W-1:0] coeff [NUM_COEFFS];
  logic signed [POINT_W-1:0] pt [3];
  logic signed [ACC_W-1:0]   acc [3];
  logic [7:0]                mem [DEPTH];
  logic [7:0]                mem_q;

  // Multiplier operand selection.
  logic [4:0]          step, srem;
  logic [1:0]          row, col;
  logic                half;
  logic [3:0]          cidx;
  logic signed [24:0]  mul_a;
  logic signed [31:0]  mul_b;
  logic signed [PROD_W-1:0] prod, prod_q;
  logic [1:0]          prow;
  logic                phalf;
  logic signed [ACC_W-1:0] term;

  always_comb begin
    step = cmd.mul_step;
    row  = (step >= 5'd12) ? 2'd2 : (step >= 5'd6) ? 2'd1 : 2'd0;
    srem = step - 5'(6 * row);
    col  = srem[2:1];
    half = srem[0];
    cidx = {row, 2'b00} + {2'b00, col};
    mul_a = half ? {coeff[cidx][47], coeff[cidx][47:24]} : {1'b0, coeff[cidx][23:0]};
    mul_b = pt[col];
    prod  = mul_a * mul_b;
    term  = phalf ? ({{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q} <<< 24)
                  : {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  end

  // Coefficient writes, point capture, multiply and accumulate.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COEFFS; i++) coeff[i] <= '0;
    end else if (cmd.accept && item.action == ACT_COEFF && item.coeff_index < 4'(NUM_COEFFS)) begin
      coeff[item.coeff_index] <= item.coeff_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.project_start) begin
      pt[0] <= item.point_x;
      pt[1] <= item.point_y;
      pt[2] <= item.point_z;
      for (int r = 0; r < 3; r++) begin
        acc[r] <= {{(ACC_W-COEFF_W-16){coeff[r*4+3][COEFF_W-1]}}, coeff[r*4+3], 16'd0};
      end
    end else if (cmd.acc_en) begin
      acc[prow] <= acc[prow] + term;
    end
    if (cmd.mul_issue) begin
      prod_q <= prod;
      prow   <= row;
      phalf  <= half;
    end
  end

  // Restoring divider shared by both pixel coordinates, one quotient bit a cycle.
  logic signed [ACC_W-1:0] num, den;
  logic signed [ACC_W:0]   nsum;
  logic [DIV_W-1:0]        num_u, den_u, rem, dsh, rem_sub;
  logic [QUOT_BITS-1:0]    q, lim, cols_lim, rows_lim, u_q, v_q;
  logic                    dneg, dok, u_ok, v_ok, h2pos, view, qbit;

  always_comb begin
    num      = cmd.sel_v ? acc[1] : acc[0];
    den      = acc[2];
    nsum     = {num[ACC_W-1], num} + {den[ACC_W-1], den};
    num_u    = {{(DIV_W-ACC_W){1'b0}}, num};
    den_u    = {{(DIV_W-ACC_W){1'b0}}, den};
    cols_lim = (QUOT_BITS'(cfg.map_cols) > QUOT_BITS'(MAP_COLS_MAX))
             ? QUOT_BITS'(MAP_COLS_MAX) : QUOT_BITS'(cfg.map_cols);
    rows_lim = (QUOT_BITS'(cfg.map_rows) > QUOT_BITS'(MAP_ROWS_MAX))
             ? QUOT_BITS'(MAP_ROWS_MAX) : QUOT_BITS'(cfg.map_rows);
    lim      = cmd.sel_v ? rows_lim : cols_lim;
    qbit     = !dneg && rem >= dsh;
    rem_sub  = rem - dsh;
    h2pos    = !acc[2][ACC_W-1] && acc[2] != '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dneg <= num[ACC_W-1];
      // A quotient in (-1, 0) truncates to pixel zero.
      dok  <= num[ACC_W-1] ? (!nsum[ACC_W] && nsum != '0 && lim != '0)
                           : (num_u < (den_u << QUOT_BITS));
      rem  <= num_u;
      dsh  <= den_u << (QUOT_BITS - 1);
      q    <= '0;
    end else if (cmd.div_step) begin
      if (qbit) rem <= rem_sub;
      q   <= {q[QUOT_BITS-2:0], qbit};
      dsh <= dsh >> 1;
    end
    if (cmd.div_latch) begin
      if (cmd.sel_v) begin
        v_q  <= q;
        v_ok <= dok && q < lim;
      end else begin
        u_q  <= q;
        u_ok <= dok && q < lim;
      end
    end
  end

  // Distance map memory.
  logic [AW-1:0] rd_addr;
  assign rd_addr = AW'(32'(v_q) * 32'(MAP_COLS_MAX) + 32'(u_q));
  assign view    = h2pos && u_ok && v_ok;

  always_ff @(posedge clk) begin
    if (cmd.accept && item.action == ACT_MAP && 32'(item.map_address) < 32'(DEPTH)) begin
      mem[AW'(item.map_address)] <= item.map_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.map_rd) mem_q <= mem[rd_addr];
  end

  // Inlier decision, counter and output register.
  logic                  inl;
  logic [COUNT_BITS-1:0] cnt, cnt_next;

  always_comb begin
    inl      = view && (8'd255 - mem_q) <= cfg.threshold;
    cnt_next = (inl && cnt < CMAX) ? cnt + 1'b1 : cnt;
  end

  assign status.out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.accept && item.action == ACT_CLEAR) begin
        cnt <= '0;
      end else if (cmd.res_load) begin
        cnt <= cnt_next;
      end
      if (cmd.res_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      result.in_view      <= view;
      result.inlier       <= inl;
      result.pixel_u      <= view ? 10'(u_q) : 10'd0;
      result.pixel_v      <= view ? 9'(v_q) : 9'd0;
      result.inlier_count <= RES_COUNT_W'(cnt_next);
    end
  end

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> result_valid)
    else $error("result load did not raise valid");
  a_inlier_view: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!result.inlier || result.in_view))
    else $error("inlier flagged outside the view");
  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(cmd.accept && item.action == ACT_CLEAR) |-> cnt >= $past(cnt))
    else $error("inlier counter fell without a clear");

endmodule
`default_nettype wire

@@ src/projected_point_mask_filter_core.sv @@
// Top level of the projected point mask filter.
// Input transactions arrive on item/item_valid/item_ready; results leave on
// result/result_valid/result_ready. Action 0 writes a projection coefficient,
// action 1 writes a distance map byte and action 3 clears the inlier counter;
// none of them yields a result, so they can follow back to back. Action 2
// projects a point and yields one result: it passes through the single
// shared 25x32 multiplier (18 partial products), then two passes of the
// restoring divider (set-up, 13 quotient bits and a latch) for the column
// and the row, one map read and one output load. Items are handled one
// at a time; item_ready is high only while the controller is idle, so a
// projection occupies the input until its result is loaded. The result sits
// in an output register, so a stalled receiver holds it while the next item
// is accepted; a following projection waits for that register before
// loading its result.
// Reset clears the coefficients, the counter and the registers to their
// defaults (threshold 150, 640 columns, 512 rows); the distance map is not
// cleared and must be written before it is read. Registers must be written
// over the APB-style port while the block is idle, which it does not enforce.
`default_nettype none
module projected_point_mask_filter_core
  import ppmf_pkg::*;
#(
  parameter int MAP_COLS_MAX = DEF_MAP_COLS_MAX,
  parameter int MAP_ROWS_MAX = DEF_MAP_ROWS_MAX,
  parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        item_valid,
  output logic             item_ready,
  input  wire item_t       item,
  output logic             result_valid,
  input  wire logic        result_ready,
  output result_t          result
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  ppmf_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  ppmf_ctrl u_ctrl (
    .clk, .rst, .item_valid, .item_action(item.action), .item_ready, .cmd, .status
  );

  ppmf_datapath #(
    .MAP_COLS_MAX(MAP_COLS_MAX),
    .MAP_ROWS_MAX(MAP_ROWS_MAX),
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk, .rst, .item, .cfg, .cmd, .status, .result_valid, .result_ready, .result
  );

endmodule
`default_nettype wire
